// File: hdl/ssev_pkg.sv
// Shared types, constants and fixed-point helpers for the spring surface evaluator.
`timescale 1ns / 1ps

package ssev_pkg;

    localparam int ROT_W = 34;
    localparam int TRIG_W = 18;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0] INV_PI_Q30 = 32'sd341782638;
    localparam logic signed [15:0] MAJOR_RESET = 16'sd6144;
    localparam logic signed [15:0] TUBE_RESET = 16'sd2048;
    localparam logic signed [15:0] PITCH_RESET = 16'sd4096;

    localparam logic [7:0] REG_MAJOR_RADIUS = 8'd0;
    localparam logic [7:0] REG_TUBE_RADIUS = 8'd1;
    localparam logic [7:0] REG_PITCH_LENGTH = 8'd2;

    localparam logic signed [ROT_W-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81
    };

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] a;
        logic                    flip;
    } t_rot;

    // One slot of the rotation chain: both angles move together.
    typedef struct packed {
        t_rot        u;
        t_rot        v;
        logic [15:0] ut;
    } t_pair;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cu;
        logic signed [TRIG_W-1:0] su;
        logic signed [TRIG_W-1:0] cv;
        logic signed [TRIG_W-1:0] sv;
        logic [15:0]              ut;
    } t_trig;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] du_x;
        logic signed [31:0] du_y;
        logic signed [31:0] du_z;
        logic signed [31:0] dv_x;
        logic signed [31:0] dv_y;
        logic signed [31:0] dv_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
    } t_result;

    // Rounds half up: floor((v + 2^(s-1)) / 2^s).
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Folds a 32-bit turn angle into a quarter turn either side of zero.
    function automatic t_rot fold(input logic [31:0] ang);
        t_rot r;
        logic signed [ROT_W-1:0] a;
        a = ROT_W'($signed(ang));
        r.x = CORDIC_GAIN_Q30;
        r.y = '0;
        r.flip = 1'b0;
        if (a > 34'sd1073741824) begin
            a = a - 34'sd2147483648;
            r.flip = 1'b1;
        end else if (a < -34'sd1073741824) begin
            a = a + 34'sd2147483648;
            r.flip = 1'b1;
        end
        r.a = a;
        return r;
    endfunction

    function automatic t_rot rot_step(input t_rot r, input logic signed [ROT_W-1:0] at,
                                      input int sh);
        t_rot n;
        n = r;
        if (r.a >= 0) begin
            n.x = r.x - (r.y >>> sh);
            n.y = r.y + (r.x >>> sh);
            n.a = r.a - at;
        end else begin
            n.x = r.x + (r.y >>> sh);
            n.y = r.y - (r.x >>> sh);
            n.a = r.a + at;
        end
        return n;
    endfunction

    function automatic logic signed [TRIG_W-1:0] finish(input logic signed [ROT_W-1:0] v,
                                                        input logic flip);
        logic signed [63:0] w;
        w = flip ? -64'(v) : 64'(v);
        w = rnd(w, 14);
        return w[TRIG_W-1:0];
    endfunction

endpackage

// File: hdl/ssev_if.sv
// Channel interfaces: parameter input, result output and register write.
`timescale 1ns / 1ps

interface ssev_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] u_turn;
    logic [15:0] v_turn;
    modport source(output valid, u_turn, v_turn, input ready);
    modport sink(input valid, u_turn, v_turn, output ready);
endinterface

interface ssev_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] du_x;
    logic signed [31:0] du_y;
    logic signed [31:0] du_z;
    logic signed [31:0] dv_x;
    logic signed [31:0] dv_y;
    logic signed [31:0] dv_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    modport source(output valid, pos_x, pos_y, pos_z, du_x, du_y, du_z, dv_x, dv_y, dv_z,
                   norm_x, norm_y, norm_z, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, du_x, du_y, du_z, dv_x, dv_y, dv_z,
                 norm_x, norm_y, norm_z, output ready);
endinterface

interface ssev_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/spring_surface_evaluator.sv
// Top level of the helical spring surface evaluator.
//
//  channel  | role   | beat contents
//  i_in     | sink   | u_turn, v_turn
//  o_out    | source | pos, du, dv, norm (x, y, z each)
//  i_cfg    | sink   | index, data (register write)
//
// One beat is accepted per cycle unless the pipeline holds; a beat passes through the fold,
// the chain of rotation cells, the rounding register and five arithmetic stages.
// The whole pipeline advances together; it holds while a result waits on o_out.
// Reset restores the three radius and pitch registers and clears all valid bits.
// Register writes are always accepted.
`timescale 1ns / 1ps

module spring_surface_evaluator #(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssev_in_if.sink     i_in,
    ssev_out_if.source  o_out,
    ssev_cfg_if.sink    i_cfg
);
    logic signed [15:0] r_major, r_tube, r_pitch;
    logic               en;
    logic               trig_valid;
    ssev_pkg::t_trig    trig;
    logic               geom_valid;
    ssev_pkg::t_result  res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= ssev_pkg::MAJOR_RESET;
            r_tube  <= ssev_pkg::TUBE_RESET;
            r_pitch <= ssev_pkg::PITCH_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ssev_pkg::REG_MAJOR_RADIUS: r_major <= i_cfg.data;
                ssev_pkg::REG_TUBE_RADIUS:  r_tube  <= i_cfg.data;
                ssev_pkg::REG_PITCH_LENGTH: r_pitch <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign en         = !geom_valid || o_out.ready;
    assign i_in.ready = en;

    ssev_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STEPS(TRIG_STEPS)) u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_u_turn (i_in.u_turn),
        .i_v_turn (i_in.v_turn),
        .o_valid  (trig_valid),
        .o_trig   (trig)
    );

    ssev_geom #(.ANGLE_BITS(ANGLE_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (trig_valid),
        .i_trig  (trig),
        .i_major (r_major),
        .i_tube  (r_tube),
        .i_pitch (r_pitch),
        .o_valid (geom_valid),
        .o_res   (res)
    );

    assign o_out.valid  = geom_valid;
    assign o_out.pos_x  = res.pos_x;
    assign o_out.pos_y  = res.pos_y;
    assign o_out.pos_z  = res.pos_z;
    assign o_out.du_x   = res.du_x;
    assign o_out.du_y   = res.du_y;
    assign o_out.du_z   = res.du_z;
    assign o_out.dv_x   = res.dv_x;
    assign o_out.dv_y   = res.dv_y;
    assign o_out.dv_z   = res.dv_z;
    assign o_out.norm_x = res.norm_x;
    assign o_out.norm_y = res.norm_y;
    assign o_out.norm_z = res.norm_z;

    a_zero_tube_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_tube == 16'sd0) |->
        (o_out.norm_x == 32'sd0 && o_out.norm_y == 32'sd0 && o_out.norm_z == 32'sd0))
        else $error("normal not zero with zero tube radius");

    a_du_y_is_pos_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.du_y == o_out.pos_x)
        else $error("du_y differs from pos_x");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result beat present right after reset");
endmodule

// File: hdl/ssev_cell.sv
// One rotation cell: a single CORDIC step for both angles, registered.
`timescale 1ns / 1ps

module ssev_cell #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  ssev_pkg::t_pair       i_data,
    output logic                  o_valid,
    output ssev_pkg::t_pair       o_data
);
    logic            r_valid;
    ssev_pkg::t_pair r_data;
    ssev_pkg::t_pair n_data;

    always_comb begin
        n_data.u  = ssev_pkg::rot_step(i_data.u, ssev_pkg::ATAN_TURN32[STEP], STEP);
        n_data.v  = ssev_pkg::rot_step(i_data.v, ssev_pkg::ATAN_TURN32[STEP], STEP);
        n_data.ut = i_data.ut;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: hdl/ssev_trig.sv
// Angle fold, chain of rotation cells and final rounding for both angles.
`timescale 1ns / 1ps

module ssev_trig #(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [15:0]     i_u_turn,
    input  logic [15:0]     i_v_turn,
    output logic            o_valid,
    output ssev_pkg::t_trig o_trig
);
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int SHL = 32 - ANGLE_BITS;

    logic [31:0]     ut_m;
    logic [31:0]     vt_m;
    logic            r_fold_valid;
    ssev_pkg::t_pair r_fold;
    logic            chain_valid [TRIG_STEPS+1];
    ssev_pkg::t_pair chain_data [TRIG_STEPS+1];
    logic            r_valid;
    ssev_pkg::t_trig r_trig;
    ssev_pkg::t_pair last;

    assign ut_m = {16'b0, i_u_turn} & AMASK;
    assign vt_m = {16'b0, i_v_turn} & AMASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
        end else if (i_en) begin
            r_fold_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold.u  <= ssev_pkg::fold(ut_m << SHL);
            r_fold.v  <= ssev_pkg::fold(vt_m << SHL);
            r_fold.ut <= ut_m[15:0];
        end
    end

    assign chain_valid[0] = r_fold_valid;
    assign chain_data[0]  = r_fold;

    for (genvar g = 0; g < TRIG_STEPS; g++) begin : g_cell
        ssev_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign last = chain_data[TRIG_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= chain_valid[TRIG_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.cu <= ssev_pkg::finish(last.u.x, last.u.flip);
            r_trig.su <= ssev_pkg::finish(last.u.y, last.u.flip);
            r_trig.cv <= ssev_pkg::finish(last.v.x, last.v.flip);
            r_trig.sv <= ssev_pkg::finish(last.v.y, last.v.flip);
            r_trig.ut <= last.ut;
        end
    end

    assign o_valid = r_valid;
    assign o_trig  = r_trig;
endmodule

// File: hdl/ssev_geom.sv
// Surface point, tangents and normal from the sines and cosines, five stages.
`timescale 1ns / 1ps

module ssev_geom #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ssev_pkg::t_trig    i_trig,
    input  logic signed [15:0] i_major,
    input  logic signed [15:0] i_tube,
    input  logic signed [15:0] i_pitch,
    output logic               o_valid,
    output ssev_pkg::t_result  o_res
);
    localparam int IW = ANGLE_BITS + 20;
    localparam int TW = ssev_pkg::TRIG_W;

    logic [4:0] r_v;

    // Stage 1
    logic signed [34:0]   r1_a;
    logic signed [33:0]   r1_rcu, r1_rsu;
    logic signed [31:0]   r1_dvz;
    logic signed [IW-1:0] r1_inner;
    logic signed [31:0]   r1_lr;
    logic signed [TW-1:0] r1_cu, r1_su, r1_cv, r1_sv;
    logic signed [33:0]   rcv;
    logic signed [32:0]   lut;
    // Stage 2
    logic signed [52:0]   r2_acu, r2_asu, r2_acv, r2_asv;
    logic signed [31:0]   r2_dvx, r2_dvy, r2_dvz, r2_posz, r2_duz;
    logic signed [32:0]   r2_lrpi;
    logic signed [TW-1:0] r2_cu, r2_su, r2_sv;
    logic signed [51:0]   p_dvx, p_dvy;
    logic signed [IW+15:0] p_posz;
    logic signed [62:0]   p_lr;
    logic signed [63:0]   lrpi_w;
    // Stage 3
    logic signed [63:0]   r3_px, r3_py;
    logic signed [39:0]   r3_acv, r3_lsv;
    logic signed [52:0]   r3_nz;
    logic signed [31:0]   r3_dvx, r3_dvy, r3_dvz, r3_posz, r3_duz;
    logic signed [TW-1:0] r3_cu, r3_su;
    logic signed [63:0]   acv_w, lsv_w;
    // Stage 4
    logic signed [63:0]   r4_nx, r4_ny, r4_nz, r4_px, r4_py;
    logic signed [31:0]   r4_dvx, r4_dvy, r4_dvz, r4_posz, r4_duz;
    logic signed [63:0]   nx_w, ny_w, nz_w;
    // Stage 5 (output register)
    ssev_pkg::t_result    r5_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    assign rcv = i_tube * i_trig.cv;
    assign lut = i_pitch * $signed({1'b0, i_trig.ut});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= (35'(i_major) <<< 16) + 35'(rcv);
            r1_rcu   <= i_tube * i_trig.cu;
            r1_rsu   <= i_tube * i_trig.su;
            r1_dvz   <= ssev_pkg::sat32(ssev_pkg::rnd(64'(rcv), 12));
            r1_inner <= (IW'(i_trig.sv) <<< (ANGLE_BITS - 4)) + (IW'(lut) <<< 1);
            r1_lr    <= i_pitch * i_tube;
            r1_cu    <= i_trig.cu;
            r1_su    <= i_trig.su;
            r1_cv    <= i_trig.cv;
            r1_sv    <= i_trig.sv;
        end
    end

    assign p_dvx  = r1_rcu * r1_sv;
    assign p_dvy  = r1_rsu * r1_sv;
    assign p_posz = r1_inner * IW'(i_tube);
    assign p_lr   = r1_lr * ssev_pkg::INV_PI_Q30;
    assign lrpi_w = ssev_pkg::rnd(64'(p_lr), 30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_acu  <= r1_a * r1_cu;
            r2_asu  <= r1_a * r1_su;
            r2_acv  <= r1_a * r1_cv;
            r2_asv  <= r1_a * r1_sv;
            r2_dvx  <= ssev_pkg::sat32(ssev_pkg::rnd(-64'(p_dvx), 28));
            r2_dvy  <= ssev_pkg::sat32(ssev_pkg::rnd(-64'(p_dvy), 28));
            r2_dvz  <= r1_dvz;
            r2_posz <= ssev_pkg::sat32(ssev_pkg::rnd(64'(p_posz), ANGLE_BITS + 8));
            r2_duz  <= ssev_pkg::sat32(ssev_pkg::rnd(64'(p_lr), 38));
            r2_lrpi <= lrpi_w[32:0];
            r2_cu   <= r1_cu;
            r2_su   <= r1_su;
            r2_sv   <= r1_sv;
        end
    end

    assign acv_w = ssev_pkg::rnd(64'(r2_acv), 16);
    assign lsv_w = ssev_pkg::rnd(64'(r2_lrpi) * 64'(r2_sv), 12);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_px   <= ssev_pkg::rnd(64'(r2_acu), 28);
            r3_py   <= ssev_pkg::rnd(64'(r2_asu), 28);
            r3_acv  <= acv_w[39:0];
            r3_lsv  <= lsv_w[39:0];
            r3_nz   <= r2_asv;
            r3_dvx  <= r2_dvx;
            r3_dvy  <= r2_dvy;
            r3_dvz  <= r2_dvz;
            r3_posz <= r2_posz;
            r3_duz  <= r2_duz;
            r3_cu   <= r2_cu;
            r3_su   <= r2_su;
        end
    end

    assign nx_w = 64'(r3_acv) * 64'(r3_cu) + 64'(r3_lsv) * 64'(r3_su);
    assign ny_w = 64'(r3_acv) * 64'(r3_su) - 64'(r3_lsv) * 64'(r3_cu);
    assign nz_w = 64'(r3_nz);

    // The normal follows the sign of the tube radius; a zero radius gives zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_tube > 16'sd0) begin
                r4_nx <= nx_w;
                r4_ny <= ny_w;
                r4_nz <= nz_w;
            end else if (i_tube < 16'sd0) begin
                r4_nx <= -nx_w;
                r4_ny <= -ny_w;
                r4_nz <= -nz_w;
            end else begin
                r4_nx <= '0;
                r4_ny <= '0;
                r4_nz <= '0;
            end
            r4_px   <= r3_px;
            r4_py   <= r3_py;
            r4_dvx  <= r3_dvx;
            r4_dvy  <= r3_dvy;
            r4_dvz  <= r3_dvz;
            r4_posz <= r3_posz;
            r4_duz  <= r3_duz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_res.pos_x  <= ssev_pkg::sat32(r4_px);
            r5_res.pos_y  <= ssev_pkg::sat32(r4_py);
            r5_res.pos_z  <= r4_posz;
            r5_res.du_x   <= ssev_pkg::sat32(-r4_py);
            r5_res.du_y   <= ssev_pkg::sat32(r4_px);
            r5_res.du_z   <= r4_duz;
            r5_res.dv_x   <= r4_dvx;
            r5_res.dv_y   <= r4_dvy;
            r5_res.dv_z   <= r4_dvz;
            r5_res.norm_x <= ssev_pkg::sat32(ssev_pkg::rnd(r4_nx, 28));
            r5_res.norm_y <= ssev_pkg::sat32(ssev_pkg::rnd(r4_ny, 28));
            r5_res.norm_z <= ssev_pkg::sat32(ssev_pkg::rnd(r4_nz, 28));
        end
    end

    assign o_valid = r_v[4];
    assign o_res   = r5_res;
endmodule

// File: sim/spring_surface_evaluator_test.sv
// Self-checking testbench for the spring surface evaluator: directed and random surface samples.
`timescale 1ns / 1ps

module spring_surface_evaluator_test;

    localparam int ANGLE_BITS = 16;
    localparam int TRIG_STEPS = 16;
    localparam int LATENCY = TRIG_STEPS + 7;
    localparam int N_RANDOM = 1300;

    typedef struct {
        logic signed [31:0] f [12];
    } t_sample;

    class surface_scoreboard;
        logic signed [15:0] major_r;
        logic signed [15:0] tube_r;
        logic signed [15:0] pitch;
        t_sample pending [$];
        int errors;

        function new();
            major_r = ssev_pkg::MAJOR_RESET;
            tube_r = ssev_pkg::TUBE_RESET;
            pitch = ssev_pkg::PITCH_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] d);
            if (idx == ssev_pkg::REG_MAJOR_RADIUS) major_r = d;
            else if (idx == ssev_pkg::REG_TUBE_RADIUS) tube_r = d;
            else if (idx == ssev_pkg::REG_PITCH_LENGTH) pitch = d;
        endfunction

        static function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rshift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        static function logic signed [31:0] clip(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        static function void sincos(logic [31:0] ang, output longint c, output longint s);
            longint a, x, y, nx;
            bit flip;
            a = longint'($signed(ang));
            x = 652032874;
            y = 0;
            flip = 0;
            if (a > 64'sd1073741824) begin
                a -= 64'sd2147483648; flip = 1;
            end else if (a < -64'sd1073741824) begin
                a += 64'sd2147483648; flip = 1;
            end
            for (int i = 0; i < TRIG_STEPS; i++) begin
                if (a >= 0) begin
                    nx = x - fshift(y, i); y = y + fshift(x, i);
                    a -= ssev_pkg::ATAN_TURN32[i];
                end else begin
                    nx = x + fshift(y, i); y = y - fshift(x, i);
                    a += ssev_pkg::ATAN_TURN32[i];
                end
                x = nx;
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = rshift(x, 14);
            s = rshift(y, 14);
        endfunction

        function void note_sample(logic [15:0] u, logic [15:0] v);
            t_sample e;
            longint cu, su, cv, sv, big_r, rr, ll, aa, px, py, inner, lr, lrpi, sg, acv, lsv;
            longint ut;
            ut = u;
            sincos({u, 16'h0}, cu, su);
            sincos({v, 16'h0}, cv, sv);
            big_r = major_r; rr = tube_r; ll = pitch;
            aa = big_r * 65536 + rr * cv;
            px = rshift(aa * cu, 28);
            py = rshift(aa * su, 28);
            inner = sv * (64'sd1 <<< (ANGLE_BITS - 4)) + 2 * ll * ut;
            lr = ll * rr;
            lrpi = rshift(lr * 341782638, 30);
            e.f[0] = clip(px);
            e.f[1] = clip(py);
            e.f[2] = clip(rshift(rr * inner, ANGLE_BITS + 8));
            e.f[3] = clip(-py);
            e.f[4] = clip(px);
            e.f[5] = clip(rshift(lr * 341782638, 38));
            e.f[6] = clip(rshift(-(rr * cu) * sv, 28));
            e.f[7] = clip(rshift(-(rr * su) * sv, 28));
            e.f[8] = clip(rshift(rr * cv, 12));
            sg = rr > 0 ? 1 : (rr < 0 ? -1 : 0);
            acv = rshift(aa * cv, 16);
            lsv = rshift(lrpi * sv, 12);
            e.f[9] = clip(rshift(sg * (acv * cu + lsv * su), 28));
            e.f[10] = clip(rshift(sg * (acv * su - lsv * cu), 28));
            e.f[11] = clip(rshift(sg * (aa * sv), 28));
            pending.push_back(e);
        endfunction

        function void check_sample(t_sample got);
            t_sample e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 12; k++) begin
                if (got.f[k] !== e.f[k]) begin
                    $display("%0t: field %0d expected %0d actual %0d", $time, k, e.f[k],
                             got.f[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ssev_in_if in_ch ();
    ssev_out_if out_ch ();
    ssev_cfg_if cfg_ch ();

    surface_scoreboard board;
    bit calm;

    spring_surface_evaluator #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STEPS(TRIG_STEPS)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    initial begin
        #4000000;
        $display("** spring_surface_evaluator: FAILED **");
        $finish;
    end

    // Result side: random stall bursts, checked on each accepted beat.
    initial begin
        int stall;
        t_sample got;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 10);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got.f[0] = out_ch.pos_x; got.f[1] = out_ch.pos_y; got.f[2] = out_ch.pos_z;
                got.f[3] = out_ch.du_x; got.f[4] = out_ch.du_y; got.f[5] = out_ch.du_z;
                got.f[6] = out_ch.dv_x; got.f[7] = out_ch.dv_y; got.f[8] = out_ch.dv_z;
                got.f[9] = out_ch.norm_x; got.f[10] = out_ch.norm_y;
                got.f[11] = out_ch.norm_z;
                board.check_sample(got);
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.write_reg(idx, d);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(logic [15:0] u, logic [15:0] v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.u_turn <= u;
        in_ch.v_turn <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_sample(u, v);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_shape(logic [15:0] rm, logic [15:0] rt, logic [15:0] pl);
        write_reg(ssev_pkg::REG_MAJOR_RADIUS, rm);
        write_reg(ssev_pkg::REG_TUBE_RADIUS, rt);
        write_reg(ssev_pkg::REG_PITCH_LENGTH, pl);
    endtask

    initial begin
        logic [15:0] corner [8];
        logic [15:0] pick;
        corner = '{16'h0000, 16'hffff, 16'h4000, 16'h8000,
                   16'hc000, 16'h2000, 16'h7fff, 16'h8001};
        board = new();
        calm = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.u_turn = '0; in_ch.v_turn = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset shape first, corner angles.
        for (int k = 0; k < 8; k++) send_sample(corner[k], corner[7 - k]);
        drain();
        // Zero tube radius gives a zero normal; an index past the list is ignored.
        set_shape(16'h1800, 16'h0000, 16'h1000);
        write_reg(8'd3, 16'h7777);
        for (int k = 0; k < 4; k++) send_sample(corner[k], corner[k + 2]);
        drain();
        // Extreme registers drive saturation; negative tube radius flips the normal.
        set_shape(16'h7fff, 16'h8000, 16'h8000);
        for (int k = 0; k < 6; k++) send_sample(corner[k], corner[(k + 3) % 8]);
        drain();
        set_shape(16'h8000, 16'h7fff, 16'h7fff);
        for (int k = 0; k < 6; k++) send_sample(corner[7 - k], corner[k]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                set_shape(ssev_pkg::MAJOR_RESET, ssev_pkg::TUBE_RESET, ssev_pkg::PITCH_RESET);
                calm = 1;
            end else begin
                pick = $urandom_range(0, 3) == 0 ? 16'h8000 : 16'($urandom());
                set_shape(16'($urandom()), pick, 16'($urandom()));
            end
            for (int k = 0; k < N_RANDOM / 6; k++)
                send_sample(16'($urandom()), 16'($urandom()));
            drain();
        end

        if (board.errors == 0)
            $display("** spring_surface_evaluator: PASSED **");
        else
            $display("** spring_surface_evaluator: FAILED **");
        $finish;
    end
endmodule

// File: files.f
hdl/ssev_pkg.sv
hdl/ssev_if.sv
hdl/ssev_cell.sv
hdl/ssev_trig.sv
hdl/ssev_geom.sv
hdl/spring_surface_evaluator.sv
sim/spring_surface_evaluator_test.sv
